// File: rtl/pcis_pkg.sv
// ----------------------------------------------------------------------------
// pcis_pkg
// Shared types, widths and codes of the piecewise-constant inverse-CDF sampler.
// ----------------------------------------------------------------------------
package pcis_pkg;

   localparam int MAX_ENTRIES   = 1024;
   localparam int IDX_BITS      = 10;
   localparam int CNT_BITS      = 11;
   localparam int WEIGHT_BITS   = 16;
   localparam int FRACTION_BITS = 16;
   localparam int CUM_BITS      = 26;
   localparam int POS_BITS      = 16;
   localparam int DENS_BITS     = 27;
   localparam int STATUS_BITS   = 2;

   // shared multiplier: CUM_BITS x MULB_BITS
   localparam int MULB_BITS = (WEIGHT_BITS > FRACTION_BITS) ? WEIGHT_BITS : FRACTION_BITS;
   localparam int PROD_BITS = CUM_BITS + MULB_BITS;
   localparam int TGT_BITS  = CUM_BITS + FRACTION_BITS;
   localparam int NUM_BITS  = TGT_BITS + 1;

   // shared restoring divider
   localparam int DIV_BITS   = WEIGHT_BITS + CNT_BITS;
   localparam int STEP_BITS  = $clog2(DIV_BITS + 1);
   localparam int DENS_STEPS = CNT_BITS + FRACTION_BITS;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_ZERO_TOTAL = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_BAD_INDEX  = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_INCOMPLETE = 2'd3;

   typedef struct packed {
      logic                     req_type;
      logic [IDX_BITS-1:0]      entry_index;
      logic [WEIGHT_BITS-1:0]   bin_weight;
      logic [FRACTION_BITS-1:0] uniform_fraction;
   } req_item_type;

   typedef struct packed {
      logic [POS_BITS-1:0]    sample_position;
      logic [IDX_BITS-1:0]    bin_index;
      logic [DENS_BITS-1:0]   density;
      logic [STATUS_BITS-1:0] status;
   } rsp_item_type;

   typedef struct packed {
      logic                 start;
      logic [STEP_BITS-1:0] steps;
   } div_cmd_type;

endpackage

// File: rtl/pcis_divider.sv
// ----------------------------------------------------------------------------
// pcis_divider
// Restoring divider, one quotient bit per cycle. The caller preloads the
// partial remainder (must be below the divisor) and the remaining dividend
// bits, MSB first, and gives the number of steps.
// ----------------------------------------------------------------------------
module pcis_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  pcis_pkg::div_cmd_type               cmd,
   input  logic [pcis_pkg::DIV_BITS-1:0]       divisor,
   input  logic [pcis_pkg::DIV_BITS-1:0]       rem_init,
   input  logic [pcis_pkg::DIV_BITS-1:0]       bits_init,
   output logic [pcis_pkg::DIV_BITS-1:0]       quotient,
   output logic                                done
);

   logic [pcis_pkg::STEP_BITS-1:0] cnt_ff, cnt_in;
   logic                           done_ff, done_in;
   logic [pcis_pkg::DIV_BITS-1:0]  rem_ff, rem_in;
   logic [pcis_pkg::DIV_BITS-1:0]  bits_ff, bits_in;
   logic [pcis_pkg::DIV_BITS-1:0]  quo_ff, quo_in;
   logic [pcis_pkg::DIV_BITS-1:0]  dvs_ff, dvs_in;
   logic [pcis_pkg::DIV_BITS:0]    trial;
   logic                           ge;

   assign trial = {rem_ff, bits_ff[pcis_pkg::DIV_BITS-1]};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      bits_in = bits_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (cmd.start) begin
         cnt_in  = cmd.steps;
         rem_in  = rem_init;
         bits_in = bits_init;
         quo_in  = '0;
         dvs_in  = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == pcis_pkg::STEP_BITS'(1));
         rem_in  = ge ? pcis_pkg::DIV_BITS'(trial - {1'b0, dvs_ff})
                      : trial[pcis_pkg::DIV_BITS-1:0];
         bits_in = bits_ff << 1;
         quo_in  = {quo_ff[pcis_pkg::DIV_BITS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// File: rtl/piecewise_constant_inverse_cdf_sampler_top.sv
// ----------------------------------------------------------------------------
// piecewise_constant_inverse_cdf_sampler_top
// Loads bin weights with running sums, then draws samples by binary search
// over the cumulative sums and interpolation inside the chosen bin.
// Load, or a sample rejected for an incomplete table: result strobe one cycle
// after start, busy stays low. Zero total: the result is given from ST_TOTAL.
// Any other sample runs a binary search (cumulative memory read, compare per
// step), then the shared multiplier and a radix-2 divider run 16 + 27 steps.
// Results cannot be stalled. Synchronous reset clears the sequencer, loaded
// count and n = 1; the weight and sum memories are not cleared.
// ----------------------------------------------------------------------------
module piecewise_constant_inverse_cdf_sampler_top #(
   parameter int MAX_ENTRIES = pcis_pkg::MAX_ENTRIES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  pcis_pkg::req_item_type            req_data,
   output logic                              rsp_strobe,
   output pcis_pkg::rsp_item_type            rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pcis_pkg::CNT_BITS-1:0]     csr_data
);

   localparam int IDX_SPAN = 1 << pcis_pkg::IDX_BITS;
   localparam int DEPTH    = (MAX_ENTRIES < IDX_SPAN) ? MAX_ENTRIES : IDX_SPAN;
   localparam int AW       = $clog2(DEPTH);
   localparam int CNT      = pcis_pkg::CNT_BITS;
   localparam int CUM      = pcis_pkg::CUM_BITS;
   localparam int FB       = pcis_pkg::FRACTION_BITS;
   localparam int WB       = pcis_pkg::WEIGHT_BITS;
   localparam int DB       = pcis_pkg::DIV_BITS;

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b0000000001,
      ST_TOTAL    = 10'b0000000010,
      ST_TGT      = 10'b0000000100,
      ST_SRCH_RD  = 10'b0000001000,
      ST_SRCH_CMP = 10'b0000010000,
      ST_FETCH    = 10'b0000100000,
      ST_PROD1    = 10'b0001000000,
      ST_PROD2    = 10'b0010000000,
      ST_DIV_POS  = 10'b0100000000,
      ST_DIV_DENS = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   logic [CNT-1:0]                 entries_ff, entries_in;
   logic [CNT-1:0]                 loaded_ff, loaded_in;
   logic                           rsp_strobe_ff, rsp_strobe_in;
   pcis_pkg::rsp_item_type         rsp_ff, rsp_in;

   logic [CUM-1:0]                 last_cum_ff, last_cum_in;
   logic [FB-1:0]                  u_ff, u_in;
   logic [CUM-1:0]                 total_ff, total_in;
   logic [pcis_pkg::TGT_BITS-1:0]  target_ff, target_in;
   logic [CNT-1:0]                 left_ff, left_in;
   logic [CNT-1:0]                 right_ff, right_in;
   logic [CNT-1:0]                 mid_ff, mid_in;
   logic [CUM-1:0]                 c_ff, c_in;
   logic [WB-1:0]                  w_ff, w_in;
   logic [pcis_pkg::NUM_BITS-1:0]  num_ff, num_in;
   logic [DB-1:0]                  wn_ff, wn_in;
   logic [pcis_pkg::POS_BITS-1:0]  pos_ff, pos_in;
   logic [pcis_pkg::PROD_BITS-1:0] mul_ff, mul_in;

   // table memories
   logic [WB-1:0]  weight_mem [DEPTH];
   logic [CUM-1:0] cum_mem [DEPTH];
   logic [CUM-1:0] cum_q_ff;
   logic [WB-1:0]  w_q_ff;
   logic           mem_we;
   logic [CNT-1:0] cum_addr_full;
   logic [AW-1:0]  cum_raddr;
   logic [AW-1:0]  w_raddr;
   logic [AW-1:0]  waddr;

   logic [CNT-1:0]                 n_eff;
   logic [CNT-1:0]                 idx_ext;
   logic                           load_ok;
   logic [CUM-1:0]                 cum_new;
   logic [CNT-1:0]                 mid;
   logic [CUM-1:0]                 mul_a;
   logic [pcis_pkg::MULB_BITS-1:0] mul_b;

   pcis_pkg::div_cmd_type div_cmd;
   logic [DB-1:0]         div_dvs, div_rem, div_bits, div_q;
   logic                  div_done;

   pcis_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd),
      .divisor   (div_dvs),
      .rem_init  (div_rem),
      .bits_init (div_bits),
      .quotient  (div_q),
      .done      (div_done)
   );

   // table size in use, saturated to [1, MAX_ENTRIES]
   always_comb begin
      if (entries_ff == '0) begin
         n_eff = CNT'(1);
      end else if (int'(entries_ff) > MAX_ENTRIES) begin
         n_eff = CNT'(MAX_ENTRIES);
      end else begin
         n_eff = entries_ff;
      end
   end

   assign idx_ext = CNT'(req_data.entry_index);
   assign load_ok = (idx_ext < n_eff) &&
                    ((req_data.entry_index == '0) || (idx_ext == loaded_ff));
   assign cum_new = ((req_data.entry_index == '0) ? '0 : last_cum_ff) + CUM'(req_data.bin_weight);
   assign mid     = CNT'(((CNT+1)'(left_ff) + (CNT+1)'(right_ff)) >> 1);
   assign waddr   = req_data.entry_index[AW-1:0];
   assign cum_raddr = cum_addr_full[AW-1:0];
   assign w_raddr   = left_ff[AW-1:0];

   always_comb begin
      state_in      = state_ff;
      entries_in    = entries_ff;
      loaded_in     = loaded_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      last_cum_in   = last_cum_ff;
      u_in          = u_ff;
      total_in      = total_ff;
      target_in     = target_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      mid_in        = mid_ff;
      c_in          = c_ff;
      w_in          = w_ff;
      num_in        = num_ff;
      wn_in         = wn_ff;
      pos_in        = pos_ff;
      mem_we        = 1'b0;
      cum_addr_full = '0;
      mul_a         = '0;
      mul_b         = '0;
      div_cmd       = '0;
      div_dvs       = '0;
      div_rem       = '0;
      div_bits      = '0;

      if (csr_valid) begin
         entries_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_data.req_type == pcis_pkg::REQ_LOAD) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = '0;
                  if (load_ok) begin
                     mem_we      = 1'b1;
                     last_cum_in = cum_new;
                     loaded_in   = idx_ext + 1'b1;
                  end else begin
                     rsp_in.status = pcis_pkg::STATUS_BAD_INDEX;
                  end
               end else if (loaded_ff < n_eff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = '0;
                  rsp_in.status = pcis_pkg::STATUS_INCOMPLETE;
               end else begin
                  cum_addr_full = n_eff - 1'b1;
                  u_in          = req_data.uniform_fraction;
                  state_in      = ST_TOTAL;
               end
            end
         end
         ST_TOTAL: begin
            total_in = cum_q_ff;
            mul_a    = cum_q_ff;
            mul_b    = pcis_pkg::MULB_BITS'(u_ff);
            left_in  = '0;
            right_in = n_eff;
            if (cum_q_ff == '0) begin
               rsp_strobe_in = 1'b1;
               rsp_in        = '0;
               rsp_in.status = pcis_pkg::STATUS_ZERO_TOTAL;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_TGT;
            end
         end
         ST_TGT: begin
            target_in = mul_ff[pcis_pkg::TGT_BITS-1:0];
            state_in  = ST_SRCH_RD;
         end
         ST_SRCH_RD: begin
            if ((right_ff - left_ff) > CNT'(1)) begin
               mid_in        = mid;
               cum_addr_full = mid - 1'b1;
               state_in      = ST_SRCH_CMP;
            end else begin
               // fetch the sum below the chosen bin
               cum_addr_full = (left_ff == '0) ? '0 : left_ff - 1'b1;
               state_in      = ST_FETCH;
            end
         end
         ST_SRCH_CMP: begin
            if ({cum_q_ff, {FB{1'b0}}} <= target_ff) begin
               left_in = mid_ff;
            end else begin
               right_in = mid_ff;
            end
            state_in = ST_SRCH_RD;
         end
         ST_FETCH: begin
            c_in     = (left_ff == '0) ? '0 : cum_q_ff;
            w_in     = w_q_ff;
            mul_a    = CUM'(left_ff);
            mul_b    = pcis_pkg::MULB_BITS'(w_q_ff);
            state_in = ST_PROD1;
         end
         ST_PROD1: begin
            // i*w*2^F + u*T - C*2^F; never negative since u*T >= C*2^F
            num_in   = pcis_pkg::NUM_BITS'({mul_ff[CUM-1:0], {FB{1'b0}}})
                     + pcis_pkg::NUM_BITS'(target_ff)
                     - pcis_pkg::NUM_BITS'({c_ff, {FB{1'b0}}});
            mul_a    = CUM'(n_eff);
            mul_b    = pcis_pkg::MULB_BITS'(w_ff);
            state_in = ST_PROD2;
         end
         ST_PROD2: begin
            wn_in         = mul_ff[DB-1:0];
            div_cmd.start = 1'b1;
            div_cmd.steps = pcis_pkg::STEP_BITS'(FB);
            div_dvs       = mul_ff[DB-1:0];
            div_rem       = DB'(num_ff >> FB);
            div_bits      = DB'(num_ff[FB-1:0]) << (DB - FB);
            state_in      = ST_DIV_POS;
         end
         ST_DIV_POS: begin
            if (div_done) begin
               pos_in        = (w_ff == '0) ? '0 : pcis_pkg::POS_BITS'(div_q);
               // w*n*2^F / T: the top bits of w*n stay below T
               div_cmd.start = 1'b1;
               div_cmd.steps = pcis_pkg::STEP_BITS'(pcis_pkg::DENS_STEPS);
               div_dvs       = DB'(total_ff);
               div_rem       = wn_ff >> CNT;
               div_bits      = wn_ff << (DB - CNT);
               state_in      = ST_DIV_DENS;
            end
         end
         ST_DIV_DENS: begin
            if (div_done) begin
               rsp_strobe_in          = 1'b1;
               rsp_in.sample_position = pos_ff;
               rsp_in.bin_index       = left_ff[pcis_pkg::IDX_BITS-1:0];
               rsp_in.density         = div_q[pcis_pkg::DENS_BITS-1:0];
               rsp_in.status          = pcis_pkg::STATUS_OK;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign mul_in = pcis_pkg::PROD_BITS'(mul_a) * pcis_pkg::PROD_BITS'(mul_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         entries_ff    <= CNT'(1);
         loaded_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         entries_ff    <= entries_in;
         loaded_ff     <= loaded_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff      <= rsp_in;
      last_cum_ff <= last_cum_in;
      u_ff        <= u_in;
      total_ff    <= total_in;
      target_ff   <= target_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      mid_ff      <= mid_in;
      c_ff        <= c_in;
      w_ff        <= w_in;
      num_ff      <= num_in;
      wn_ff       <= wn_in;
      pos_ff      <= pos_in;
      mul_ff      <= mul_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         weight_mem[waddr] <= req_data.bin_weight;
         cum_mem[waddr]    <= cum_new;
      end
      cum_q_ff <= cum_mem[cum_raddr];
      w_q_ff   <= weight_mem[w_raddr];
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;
   assign csr_ready  = 1'b1;

endmodule

// File: rtl/pcis_checker.sv
// ----------------------------------------------------------------------------
// pcis_checker
// Port-level checks of the sampler: result timing against transfers in and
// the fixed shape of load results.
// ----------------------------------------------------------------------------
module pcis_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input pcis_pkg::req_item_type        req_data,
   input logic                          rsp_strobe,
   input pcis_pkg::rsp_item_type        rsp_data
);

   logic load_xfer;
   assign load_xfer = start && !busy && (req_data.req_type == pcis_pkg::REQ_LOAD);

   // reset leaves the block idle with no result pending
   property p_reset_quiet;
      @(posedge clock) reset |=> (!rsp_strobe && !busy);
   endproperty
   a_reset_quiet: assert property (p_reset_quiet)
      else $error("result or busy right after reset");

   // a load always answers in the next cycle, with zeroed sample fields
   property p_load_result;
      @(posedge clock) disable iff (reset)
         load_xfer |=> (rsp_strobe && !busy &&
                        (rsp_data.sample_position == '0) &&
                        (rsp_data.bin_index == '0) &&
                        (rsp_data.density == '0) &&
                        ((rsp_data.status == pcis_pkg::STATUS_OK) ||
                         (rsp_data.status == pcis_pkg::STATUS_BAD_INDEX)));
   endproperty
   a_load_result: assert property (p_load_result)
      else $error("load transfer without a proper result");

   // a result only follows an accepted transfer or running work
   property p_no_stray_result;
      @(posedge clock) disable iff (reset)
         rsp_strobe |-> ($past(start && !busy) || $past(busy));
   endproperty
   a_no_stray_result: assert property (p_no_stray_result)
      else $error("result without a transfer in");

   // the result shows while the block has gone back to idle
   property p_result_idle;
      @(posedge clock) disable iff (reset)
         rsp_strobe |-> !busy;
   endproperty
   a_result_idle: assert property (p_result_idle)
      else $error("result while busy");

endmodule

bind piecewise_constant_inverse_cdf_sampler_top pcis_checker u_pcis_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
